// ----- sv/weekly_alarm_table_matcher_defines.svh -----
// assertion macros shared by the alarm table matcher
`ifndef WEEKLY_ALARM_TABLE_MATCHER_DEFINES_SVH
`define WEEKLY_ALARM_TABLE_MATCHER_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define WATM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define WATM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define WATM_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WATM_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/watm_pkg.sv -----
package watm_pkg;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic       time_set;
		logic       slot_enabled;
		logic [6:0] repeat_mask;
		logic       skip_flag;
	} alarm_entry_t;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_DISMISS = 2'd2;
	localparam logic [1:0] CMD_QUERY   = 2'd3;

	localparam int          MIN_PER_HOUR  = 60;
	localparam int          MIN_PER_DAY   = 1440;
	localparam int          DAYS_PER_WEEK = 7;
	localparam logic [13:0] DELTA_MAX     = 14'd10080;

endpackage

// ----- sv/watm_table.sv -----
`include "weekly_alarm_table_matcher_defines.svh"

module watm_table #(
	parameter int ALARM_SLOTS = 16,
	parameter int AW          = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  watm_pkg::alarm_entry_t wr_data,
	input  logic [AW-1:0]         rd_addr,
	output watm_pkg::alarm_entry_t rd_data
);

	watm_pkg::alarm_entry_t mem [ALARM_SLOTS];
	watm_pkg::alarm_entry_t rd_q;
	logic [ALARM_SLOTS-1:0]  valid_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// never-written slots read as cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

	`WATM_ASSERT_NEXT(a_write_marks_valid, clk, arst_n, wr_en, valid_q[$past(wr_addr)])

endmodule

// ----- sv/weekly_alarm_table_matcher.sv -----
// Weekly alarm table matcher.
// Input words arrive on s_tvalid/s_tready with the command in s_tuser and the
// slot, time, stamp and slot settings in s_tdata. Every input word yields one
// result word on m_tvalid/m_tready. The user must write master_enable through
// cfg_wr_en/cfg_wr_data only while the block is idle; nothing enforces it.
// Write and dismiss: the result word is valid in the cycle after acceptance.
// Tick: unless master_enable is clear, ringing is set or the stamp is the
// last fired one, the slot table is read one slot per cycle from the slot
// store and checked against the current time, stopping at the first match.
// Query: one read of the slot, then up to eight steps of one shared adder
// that walks forward a day at a time.
// One word is in flight at a time: s_tready is high only while idle and a
// stalled result word holds until m_tready, blocking further input.
// Reset clears the table (all slots unset and disabled), the last fired
// minute and the ringing flag, and sets master_enable.
module weekly_alarm_table_matcher #(
	parameter int ALARM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[3:0] hour[8:4] minute[14:9] weekday[17:15] minute_stamp[49:18]
	// time_set[50] slot_enabled[51] repeat_mask[58:52] skip_flag[59], pad
	input  logic [63:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// fired[0] fired_slot[4:1] skip_spent[5] save_needed[6] next_found[7]
	// next_delta_minutes[21:8], pad
	output logic [23:0] m_tdata
);

	localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int CW = $clog2(ALARM_SLOTS + 1);
	localparam int SW = (AW > 4) ? AW : 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_Q_WAIT,
		ST_Q_INIT,
		ST_Q_STEP,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [3:0]  in_slot;
	logic [4:0]  in_hour;
	logic [5:0]  in_minute;
	logic [2:0]  in_weekday;
	logic [31:0] in_stamp;
	logic [SW-1:0] slot_ext;
	logic [AW-1:0] in_addr;
	logic        slot_ok;
	logic        accept;
	logic        tick_go;

	logic [CW-1:0] idx_q;
	logic          pend_s1;
	logic [AW-1:0] chk_idx_s1;
	logic [SW-1:0] chk_ext;
	logic [4:0]    hour_q;
	logic [5:0]    minute_q;
	logic [2:0]    weekday_q;
	logic [31:0]   stamp_q;
	logic          master_q;
	logic          ringing_q;
	logic [31:0]   last_fire_q;

	logic signed [14:0] acc_q;
	logic [2:0]         off_q;
	logic [2:0]         day_q;
	logic [6:0]         rep_q;

	logic        fired_q;
	logic [3:0]  fired_slot_q;
	logic        skip_spent_q;
	logic        save_q;
	logic        found_q;
	logic [13:0] delta_q;

	watm_pkg::alarm_entry_t ent;
	watm_pkg::alarm_entry_t new_ent;
	watm_pkg::alarm_entry_t wb_ent;
	logic          tbl_wr_en;
	logic [AW-1:0] tbl_wr_addr;
	watm_pkg::alarm_entry_t tbl_wr_data;

	logic [7:0]  rep8;
	logic        scan_hit;
	logic        scan_done;
	logic [10:0] ring_min;
	logic [10:0] now_min;
	logic signed [14:0] diff;
	logic [7:0]  qrep8;
	logic        step_hit;
	logic [13:0] acc_sat;

	assign in_slot    = s_tdata[3:0];
	assign in_hour    = s_tdata[8:4];
	assign in_minute  = s_tdata[14:9];
	assign in_weekday = s_tdata[17:15];
	assign in_stamp   = s_tdata[49:18];

	assign slot_ext = SW'(in_slot);
	assign in_addr  = slot_ext[AW-1:0];
	assign slot_ok  = int'(in_slot) < ALARM_SLOTS;
	assign accept   = s_tvalid && s_tready;
	assign tick_go  = master_q && !ringing_q &&
		!((in_stamp != 32'd0) && (in_stamp == last_fire_q));

	assign new_ent.hour         = in_hour;
	assign new_ent.minute       = in_minute;
	assign new_ent.time_set     = s_tdata[50];
	assign new_ent.slot_enabled = s_tdata[51];
	assign new_ent.repeat_mask  = s_tdata[58:52];
	assign new_ent.skip_flag    = s_tdata[59];

	// scan check on the word read last cycle
	assign rep8      = {1'b0, ent.repeat_mask};
	assign scan_hit  = pend_s1 && ent.slot_enabled && ent.time_set &&
		(ent.hour == hour_q) && (ent.minute == minute_q) &&
		((ent.repeat_mask == 7'd0) || rep8[weekday_q]);
	assign scan_done = !pend_s1 && (idx_q == CW'(ALARM_SLOTS));

	always_comb begin
		wb_ent = ent;
		wb_ent.skip_flag = 1'b0;
		if (ent.repeat_mask == 7'd0) begin
			wb_ent.slot_enabled = 1'b0;
		end
	end

	always_comb begin
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = chk_idx_s1;
		tbl_wr_data = wb_ent;
		if (state_q == ST_IDLE) begin
			tbl_wr_en   = accept && (s_tuser == watm_pkg::CMD_WRITE) && slot_ok;
			tbl_wr_addr = in_addr;
			tbl_wr_data = new_ent;
		end else if (state_q == ST_SCAN) begin
			tbl_wr_en = scan_hit && (ent.skip_flag || (ent.repeat_mask == 7'd0));
		end
	end

	watm_table #(
		.ALARM_SLOTS(ALARM_SLOTS),
		.AW(AW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(tbl_wr_en),
		.wr_addr(tbl_wr_addr),
		.wr_data(tbl_wr_data),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(ent)
	);

	// minutes of day and the shared day-step adder
	assign ring_min  = 11'(ent.hour) * 11'(watm_pkg::MIN_PER_HOUR) + 11'(ent.minute);
	assign now_min   = 11'(hour_q) * 11'(watm_pkg::MIN_PER_HOUR) + 11'(minute_q);
	assign diff      = $signed({4'b0, ring_min}) - $signed({4'b0, now_min});
	assign qrep8     = {1'b0, rep_q};
	assign step_hit  = qrep8[day_q] && !((off_q == 3'd0) && (acc_q <= 15'sd0));

	always_comb begin
		if (acc_q < 15'sd0) begin
			acc_sat = 14'd0;
		end else if (acc_q > $signed({1'b0, watm_pkg::DELTA_MAX})) begin
			acc_sat = watm_pkg::DELTA_MAX;
		end else begin
			acc_sat = acc_q[13:0];
		end
	end

	assign chk_ext = SW'(chk_idx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			master_q     <= 1'b1;
			ringing_q    <= 1'b0;
			last_fire_q  <= '0;
			idx_q        <= '0;
			pend_s1      <= 1'b0;
			chk_idx_s1   <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			weekday_q    <= '0;
			stamp_q      <= '0;
			acc_q        <= '0;
			off_q        <= '0;
			day_q        <= '0;
			rep_q        <= '0;
			fired_q      <= 1'b0;
			fired_slot_q <= '0;
			skip_spent_q <= 1'b0;
			save_q       <= 1'b0;
			found_q      <= 1'b0;
			delta_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				master_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fired_q      <= 1'b0;
						fired_slot_q <= '0;
						skip_spent_q <= 1'b0;
						save_q       <= 1'b0;
						found_q      <= 1'b0;
						delta_q      <= '0;
						hour_q       <= in_hour;
						minute_q     <= in_minute;
						weekday_q    <= in_weekday;
						stamp_q      <= in_stamp;
						state_q      <= ST_OUT;
						case (s_tuser)
							watm_pkg::CMD_TICK: begin
								if (tick_go) begin
									idx_q   <= '0;
									pend_s1 <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							watm_pkg::CMD_DISMISS: begin
								ringing_q <= 1'b0;
							end
							watm_pkg::CMD_QUERY: begin
								if (slot_ok) begin
									idx_q   <= CW'(in_addr);
									state_q <= ST_Q_WAIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						pend_s1     <= 1'b0;
						last_fire_q <= stamp_q;
						state_q     <= ST_OUT;
						if (ent.skip_flag) begin
							skip_spent_q <= 1'b1;
							save_q       <= 1'b1;
						end else begin
							save_q       <= (ent.repeat_mask == 7'd0);
							ringing_q    <= 1'b1;
							fired_q      <= 1'b1;
							fired_slot_q <= chk_ext[3:0];
						end
					end else if (scan_done) begin
						state_q <= ST_OUT;
					end else if (idx_q != CW'(ALARM_SLOTS)) begin
						chk_idx_s1 <= idx_q[AW-1:0];
						pend_s1    <= 1'b1;
						idx_q      <= idx_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				ST_Q_WAIT: begin
					state_q <= ST_Q_INIT;
				end
				ST_Q_INIT: begin
					acc_q   <= diff;
					off_q   <= '0;
					day_q   <= (weekday_q == 3'(watm_pkg::DAYS_PER_WEEK)) ? 3'd0 : weekday_q;
					rep_q   <= ent.repeat_mask;
					state_q <= ST_OUT;
					if (ent.slot_enabled && ent.time_set) begin
						if (ent.repeat_mask != 7'd0) begin
							state_q <= ST_Q_STEP;
						end else if (diff > 15'sd0) begin
							found_q <= 1'b1;
							delta_q <= diff[13:0];
						end
					end
				end
				ST_Q_STEP: begin
					if (step_hit) begin
						found_q <= 1'b1;
						delta_q <= acc_sat;
						state_q <= ST_OUT;
					end else if (off_q == 3'(watm_pkg::DAYS_PER_WEEK)) begin
						state_q <= ST_OUT;
					end else begin
						off_q <= off_q + 3'd1;
						acc_q <= acc_q + 15'(watm_pkg::MIN_PER_DAY);
						day_q <= (day_q == 3'(watm_pkg::DAYS_PER_WEEK - 1)) ? 3'd0
							: day_q + 3'd1;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {2'b00, delta_q, found_q, save_q, skip_spent_q, fired_slot_q, fired_q};

	`WATM_ASSERT_IMP(a_one_word_in_flight, clk, arst_n, s_tready, !m_tvalid)
	`WATM_ASSERT_IMP(a_fired_sets_ringing, clk, arst_n, m_tvalid && fired_q, ringing_q)
	`WATM_ASSERT_IMP(a_fire_or_skip, clk, arst_n, m_tvalid, !(fired_q && skip_spent_q))

endmodule

// ----- bench/weekly_alarm_table_matcher_tb.sv -----
`timescale 1ns / 100ps

module weekly_alarm_table_matcher_tb;

	localparam int ALARM_SLOTS = 16;
	localparam int LIMIT = 400000;
	localparam int TAIL = 40;

	// skip_flag is the highest field, slot the lowest, as on s_tdata
	typedef struct packed {
		logic        skip_flag;
		logic [6:0]  repeat_mask;
		logic        slot_enabled;
		logic        time_set;
		logic [31:0] minute_stamp;
		logic [2:0]  weekday;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [3:0]  slot;
	} alarm_word_t;

	// laid out as on m_tdata[21:0]
	typedef struct packed {
		logic [13:0] delta;
		logic        next_found;
		logic        save_needed;
		logic        skip_spent;
		logic [3:0]  fired_slot;
		logic        fired;
	} alarm_result_t;

	class alarm_checker;
		watm_pkg::alarm_entry_t slots[ALARM_SLOTS];
		logic [31:0] last_fire;
		bit ringing;
		bit master_en;
		alarm_result_t due_results[$];
		int faults, n_checked, n_rings, n_skips, n_found, n_writes, n_ticks;

		function new();
			foreach (slots[i])
				slots[i] = '0;
			last_fire = '0;
			ringing = 0;
			master_en = 1;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function bit minutes_to_ring(watm_pkg::alarm_entry_t e, int h, int m, int wd,
				output logic [13:0] delta);
			int now_m, alarm_m, d, day;
			bit hit;
			delta = '0;
			if (!e.slot_enabled || !e.time_set)
				return 0;
			now_m = h * watm_pkg::MIN_PER_HOUR + m;
			alarm_m = int'(e.hour) * watm_pkg::MIN_PER_HOUR + int'(e.minute);
			hit = 0;
			d = 0;
			if (e.repeat_mask == '0) begin
				if (alarm_m <= now_m)
					return 0;
				d = alarm_m - now_m;
				hit = 1;
			end else begin
				for (int off = 0; off <= watm_pkg::DAYS_PER_WEEK && !hit; off++) begin
					day = (wd + off) % watm_pkg::DAYS_PER_WEEK;
					if (e.repeat_mask[day] && !(off == 0 && alarm_m <= now_m)) begin
						d = off * watm_pkg::MIN_PER_DAY + alarm_m - now_m;
						hit = 1;
					end
				end
			end
			if (!hit)
				return 0;
			if (d < 0)
				d = 0;
			if (d > int'(watm_pkg::DELTA_MAX))
				d = int'(watm_pkg::DELTA_MAX);
			delta = d[13:0];
			return 1;
		endfunction

		function void note_word(logic [1:0] cmd, alarm_word_t w);
			alarm_result_t r;
			watm_pkg::alarm_entry_t e;
			r = '0;
			case (cmd)
				watm_pkg::CMD_WRITE: begin
					e.hour = w.hour;
					e.minute = w.minute;
					e.time_set = w.time_set;
					e.slot_enabled = w.slot_enabled;
					e.repeat_mask = w.repeat_mask;
					e.skip_flag = w.skip_flag;
					slots[w.slot] = e;
					n_writes++;
				end
				watm_pkg::CMD_DISMISS: begin
					ringing = 0;
				end
				watm_pkg::CMD_QUERY: begin
					r.next_found = minutes_to_ring(slots[w.slot], w.hour, w.minute,
						w.weekday, r.delta);
					n_found += r.next_found;
				end
				default: begin
					n_ticks++;
					if (master_en && !ringing &&
							!(w.minute_stamp != 0 && w.minute_stamp == last_fire)) begin
						for (int i = 0; i < ALARM_SLOTS; i++) begin
							e = slots[i];
							if (!e.slot_enabled || !e.time_set || e.hour != w.hour ||
									e.minute != w.minute)
								continue;
							if (e.repeat_mask != '0 &&
									(w.weekday >= watm_pkg::DAYS_PER_WEEK ||
									!e.repeat_mask[w.weekday]))
								continue;
							last_fire = w.minute_stamp;
							if (e.repeat_mask == '0) begin
								e.slot_enabled = 0;
								r.save_needed = 1;
							end
							if (e.skip_flag) begin
								e.skip_flag = 0;
								r.skip_spent = 1;
								r.save_needed = 1;
								n_skips++;
							end else begin
								ringing = 1;
								r.fired = 1;
								r.fired_slot = i[3:0];
								n_rings++;
							end
							slots[i] = e;
							break;
						end
					end
				end
			endcase
			due_results.push_back(r);
		endfunction

		function void check_word(logic [23:0] d);
			alarm_result_t got, want;
			got = d[21:0];
			n_checked++;
			if (due_results.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result word %h", d);
				return;
			end
			want = due_results.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= 10)
					$display({"mismatch: expected fired=%0d slot=%0d skip=%0d save=%0d ",
						"found=%0d delta=%0d, got fired=%0d slot=%0d skip=%0d save=%0d ",
						"found=%0d delta=%0d"},
						want.fired, want.fired_slot, want.skip_spent, want.save_needed,
						want.next_found, want.delta, got.fired, got.fired_slot,
						got.skip_spent, got.save_needed, got.next_found, got.delta);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	alarm_checker sb;
	bit calm;
	logic [4:0]  now_hour;
	logic [5:0]  now_min;
	logic [2:0]  now_wd;
	logic [31:0] now_stamp;
	int cycles;

	weekly_alarm_table_matcher #(.ALARM_SLOTS(ALARM_SLOTS)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls except in the calm stretch
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_word(m_tdata);
		m_tready <= calm || ($urandom_range(99) >= 30);
	end

	initial begin
		for (cycles = 0; cycles < LIMIT; cycles++)
			@(posedge clk);
		$display("weekly_alarm_table_matcher_tb failed");
		$finish;
	end

	task automatic push_word(input logic [1:0] cmd, input alarm_word_t w);
		if (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 30)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, w};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_word(cmd, w);
	endtask

	// unused fields carry random noise
	function automatic alarm_word_t noise_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[59:0];
	endfunction

	task automatic tick(input logic [4:0] h, input logic [5:0] m, input logic [2:0] wd,
			input logic [31:0] stamp);
		alarm_word_t w;
		w = noise_word();
		w.hour = h;
		w.minute = m;
		w.weekday = wd;
		w.minute_stamp = stamp;
		push_word(watm_pkg::CMD_TICK, w);
	endtask

	task automatic write_slot(input logic [3:0] s, input logic [4:0] h,
			input logic [5:0] m, input logic set, input logic en, input logic [6:0] rep,
			input logic skip);
		alarm_word_t w;
		w = noise_word();
		w.slot = s;
		w.hour = h;
		w.minute = m;
		w.time_set = set;
		w.slot_enabled = en;
		w.repeat_mask = rep;
		w.skip_flag = skip;
		push_word(watm_pkg::CMD_WRITE, w);
	endtask

	task automatic dismiss();
		push_word(watm_pkg::CMD_DISMISS, noise_word());
	endtask

	task automatic query(input logic [3:0] s, input logic [4:0] h, input logic [5:0] m,
			input logic [2:0] wd);
		alarm_word_t w;
		w = noise_word();
		w.slot = s;
		w.hour = h;
		w.minute = m;
		w.weekday = wd;
		push_word(watm_pkg::CMD_QUERY, w);
	endtask

	task automatic drain_words();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic set_enable(input logic v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.master_en = v;
	endtask

	task automatic run_random(input int count);
		int k, pick;
		logic [4:0] h;
		logic [5:0] m;
		logic [6:0] rep;
		logic [31:0] stamp;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(99);
			if (k < 22) begin
				h = ($urandom_range(99) < 60) ? now_hour : 5'($urandom_range(31));
				m = ($urandom_range(99) < 60) ? now_min : 6'($urandom_range(63));
				case ($urandom_range(2))
					0: rep = '0;
					1: rep = 7'($urandom_range(127)) |
						((now_wd < watm_pkg::DAYS_PER_WEEK) ? 7'(1 << now_wd) : 7'd0);
					default: rep = 7'($urandom_range(127));
				endcase
				write_slot(4'($urandom_range(15)), h, m, $urandom_range(99) < 85,
					$urandom_range(99) < 85, rep, $urandom_range(99) < 25);
			end else if (k < 60) begin
				// move the wall clock on now and then, often onto a stored alarm time
				if ($urandom_range(99) < 20) begin
					now_stamp = ($urandom_range(19) == 0) ? $urandom : now_stamp + 1;
					if ($urandom_range(99) < 40) begin
						pick = $urandom_range(ALARM_SLOTS - 1);
						now_hour = sb.slots[pick].hour;
						now_min = sb.slots[pick].minute;
					end else begin
						now_hour = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
							5'($urandom_range(23));
						now_min = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) :
							6'($urandom_range(59));
					end
					now_wd = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6));
				end
				case ($urandom_range(9))
					0: stamp = '0;
					1: stamp = $urandom;
					default: stamp = now_stamp;
				endcase
				tick(now_hour, now_min, now_wd, stamp);
			end else if (k < 72) begin
				dismiss();
			end else if ($urandom_range(1) == 0) begin
				query(4'($urandom_range(15)), now_hour, now_min, now_wd);
			end else begin
				query(4'($urandom_range(15)), 5'($urandom_range(31)), 6'($urandom_range(63)),
					3'($urandom_range(7)));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = watm_pkg::CMD_TICK;
		m_tready = 1'b0;
		calm = 0;
		now_hour = 5'd8;
		now_min = 6'd15;
		now_wd = 3'd1;
		now_stamp = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_enable(1'b1);

		query(4'd0, 5'd0, 6'd0, 3'd0);
		tick(5'd0, 6'd0, 3'd0, 32'd0);
		write_slot(4'd15, 5'd23, 6'd59, 1'b1, 1'b1, 7'h00, 1'b0);
		query(4'd15, 5'd0, 6'd0, 3'd0);
		tick(5'd23, 6'd59, 3'd3, 32'd100);
		// ringing blocks further ticks
		tick(5'd23, 6'd59, 3'd3, 32'd101);
		dismiss();
		dismiss();
		write_slot(4'd0, 5'd7, 6'd30, 1'b1, 1'b1, 7'h7f, 1'b1);
		tick(5'd7, 6'd30, 3'd2, 32'd200);
		// same minute stamp again is suppressed, unknown stamp is not
		tick(5'd7, 6'd30, 3'd2, 32'd200);
		tick(5'd7, 6'd30, 3'd2, 32'd0);
		dismiss();
		write_slot(4'd1, 5'd31, 6'd63, 1'b1, 1'b1, 7'h40, 1'b0);
		query(4'd1, 5'd0, 6'd0, 3'd7);
		tick(5'd31, 6'd63, 3'd7, 32'hffff_ffff);
		write_slot(4'd2, 5'd12, 6'd0, 1'b0, 1'b1, 7'h00, 1'b0);
		query(4'd2, 5'd0, 6'd0, 3'd0);
		query(4'd0, 5'd7, 6'd30, 3'd2);
		// sunday only, asked late on sunday: found only after walking the full week
		write_slot(4'd3, 5'd0, 6'd0, 1'b1, 1'b1, 7'h01, 1'b0);
		query(4'd3, 5'd23, 6'd59, 3'd0);
		query(4'd3, 5'd31, 6'd63, 3'd6);
		write_slot(4'd4, 5'd5, 6'd5, 1'b1, 1'b0, 7'h00, 1'b0);
		write_slot(4'd5, 5'd5, 6'd5, 1'b1, 1'b1, 7'h7f, 1'b0);
		write_slot(4'd6, 5'd5, 6'd5, 1'b1, 1'b1, 7'h00, 1'b1);
		tick(5'd5, 6'd5, 3'd1, 32'd300);
		query(4'd6, 5'd6, 6'd0, 3'd1);
		drain_words();

		set_enable(1'b0);
		dismiss();
		tick(5'd7, 6'd30, 3'd3, 32'd400);
		run_random(250);
		drain_words();

		set_enable(1'b1);
		run_random(600);
		calm = 1;
		run_random(300);
		calm = 0;
		run_random(500);
		drain_words();
		repeat (TAIL) @(posedge clk);

		$display("%0d result words checked over %0d ticks and %0d slot writes",
			sb.n_checked, sb.n_ticks, sb.n_writes);
		$display("%0d alarms rang, %0d skips spent, %0d queries found a next ring",
			sb.n_rings, sb.n_skips, sb.n_found);
		if (sb.faults == 0 && sb.pending() == 0) begin
			$display("weekly_alarm_table_matcher_tb passed");
		end else begin
			$display("weekly_alarm_table_matcher_tb failed");
		end
		$finish;
	end

endmodule

// ----- weekly_alarm_table_matcher.f -----
+incdir+sv
sv/watm_pkg.sv
sv/watm_table.sv
sv/weekly_alarm_table_matcher.sv
bench/weekly_alarm_table_matcher_tb.sv
